FILE: rtl/racl_pkg.sv
// Package for the range add / count-below block: command and result payload types,
// field widths, array sizes and operation codes.
// No dependencies.
`timescale 1ns / 1ps
package racl_pkg;

  localparam int MAX_ELEMENTS = 1024;
  localparam int BUCKET_LEN = 32;

  localparam int IDX_W = 11;
  localparam int VAL_W = 32;
  localparam int ELEM_W = 64;

  localparam logic [1:0] FUNC_LOAD = 2'd0;
  localparam logic [1:0] FUNC_ADD = 2'd1;
  localparam logic [1:0] FUNC_COUNT = 2'd2;
  localparam logic [1:0] FUNC_NONE = 2'd3;

  typedef struct packed {
    logic [1:0] func;
    logic [IDX_W-1:0] index_start;
    logic [IDX_W-1:0] index_end;
    logic signed [VAL_W-1:0] operand_value;
  } in_t;

  typedef struct packed {
    logic [IDX_W-1:0] count;
    logic range_error;
  } out_t;

endpackage

FILE: rtl/racl_ram.sv
// Single-port synchronous RAM with a registered read.
// No dependencies.
`timescale 1ns / 1ps
module racl_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024,
  parameter int AW = 10
) (
  input logic clk,
  input logic we,
  input logic [AW-1:0] addr,
  input logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

FILE: rtl/range_add_count_less_than.sv
// Range add / count-below over an array of signed 64-bit elements in buckets of
// BUCKET_LEN (a power of two). A command is taken when start is high and busy is
// low; its one result shows on result for a single cycle with done high and must
// be taken then. Errors, empty ranges and the unused code finish without a walk,
// with busy staying low. A load passes once through S_RD and S_EX. Add and count
// walk the range one element at a time, through S_RD and S_EX for each element;
// an add passes through them once for each bucket that lies wholly inside the
// range and is not the last bucket. After reset the pending-add RAM is cleared,
// one bucket per cycle, with busy high. Writing array_length is registered; it
// may be written only while busy is low.
// Depends on racl_pkg and racl_ram.
`timescale 1ns / 1ps
module range_add_count_less_than
  import racl_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic start,
  output logic busy,
  input in_t cmd,
  output logic done,
  output out_t result,
  input logic cfg_we,
  input logic [IDX_W-1:0] cfg_data
);

  localparam int NB = (MAX_ELEMENTS + BUCKET_LEN - 1) / BUCKET_LEN;
  localparam int AW = $clog2(MAX_ELEMENTS);
  localparam int BW = (NB > 1) ? $clog2(NB) : 1;
  localparam int L = $clog2(BUCKET_LEN);

  localparam logic [2:0] S_CLR = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_RD = 3'd2;
  localparam logic [2:0] S_EX = 3'd3;

  logic [2:0] state, state_next;
  logic [BW-1:0] clr;
  logic [IDX_W-1:0] array_length;
  logic [1:0] func;
  logic [IDX_W-1:0] idx, idx_next, idx_end;
  logic [IDX_W-1:0] lb, rb;
  logic first_part;
  logic [ELEM_W-1:0] value;
  logic [IDX_W-1:0] cnt;

  // element and pending RAM ports
  logic elem_we, pend_we;
  logic [ELEM_W-1:0] elem_wdata, elem_rdata, pend_wdata, pend_rdata;
  logic [BW-1:0] pend_addr;

  logic accept;
  logic cmd_err, cmd_empty;
  logic [IDX_W-1:0] cur_b;
  logic per_elem;
  logic hit;
  logic last;

  assign busy = (state != S_IDLE);
  assign accept = start && !busy;
  assign cur_b = idx >> L;
  assign per_elem = (cur_b == rb) || ((cur_b == lb) && first_part);
  assign hit = $signed(elem_rdata) < $signed(value - pend_rdata);

  always_comb begin
    cmd_err = 1'b0;
    cmd_empty = 1'b0;
    unique case (cmd.func) inside
      FUNC_LOAD: cmd_err = (cmd.index_start >= array_length);
      FUNC_ADD, FUNC_COUNT: begin
        cmd_err = (cmd.index_start > cmd.index_end) || (cmd.index_end > array_length);
        cmd_empty = (cmd.index_start == cmd.index_end);
      end
      default: cmd_empty = 1'b1;
    endcase
  end

  // next element position and write data in the execute step, and the pending clear after reset
  always_comb begin
    elem_we = 1'b0;
    pend_we = 1'b0;
    elem_wdata = elem_rdata + value;
    pend_wdata = pend_rdata + value;
    idx_next = idx + 1'b1;
    if (state == S_CLR) begin
      pend_we = 1'b1;
      pend_wdata = '0;
    end else if (state == S_EX) begin
      case (func)
        FUNC_LOAD: begin
          elem_we = 1'b1;
          elem_wdata = value - pend_rdata;
          idx_next = idx_end;
        end
        FUNC_ADD: begin
          if (per_elem) begin
            elem_we = 1'b1;
          end else begin
            // whole bucket inside the range: raise its pending add, skip to the next
            pend_we = 1'b1;
            idx_next = IDX_W'((cur_b + 1'b1) << L);
          end
        end
        default: ;
      endcase
    end
  end

  assign last = (idx_next == idx_end);
  assign pend_addr = (state == S_CLR) ? clr : BW'(cur_b);

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLR: if (clr == BW'(NB - 1)) state_next = S_IDLE;
      S_IDLE: if (accept && !cmd_err && !cmd_empty) state_next = S_RD;
      S_RD: state_next = S_EX;
      S_EX: state_next = last ? S_IDLE : S_RD;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
      clr <= '0;
      array_length <= '0;
      done <= 1'b0;
    end else begin
      state <= state_next;
      done <= 1'b0;
      if (state == S_CLR) begin
        clr <= clr + 1'b1;
      end
      if (cfg_we) begin
        if (32'(cfg_data) > MAX_ELEMENTS) begin
          array_length <= IDX_W'(MAX_ELEMENTS);
        end else begin
          array_length <= cfg_data;
        end
      end
      if (accept && (cmd_err || cmd_empty)) begin
        done <= 1'b1;
      end
      if (state == S_EX && last) begin
        done <= 1'b1;
      end
    end
  end

  // command, walk and result registers
  always_ff @(posedge clk) begin
    if (accept) begin
      func <= cmd.func;
      idx <= cmd.index_start;
      idx_end <= (cmd.func == FUNC_LOAD) ? cmd.index_start + 1'b1 : cmd.index_end;
      lb <= cmd.index_start >> L;
      rb <= (cmd.index_end - 1'b1) >> L;
      first_part <= (cmd.index_start[L-1:0] != '0);
      value <= {{(ELEM_W - VAL_W){cmd.operand_value[VAL_W-1]}}, cmd.operand_value};
      cnt <= '0;
      result.count <= '0;
      result.range_error <= cmd_err;
    end else if (state == S_EX) begin
      idx <= idx_next;
      if (func == FUNC_COUNT && hit) begin
        cnt <= cnt + 1'b1;
      end
      if (last) begin
        result.count <= (func == FUNC_COUNT) ? cnt + IDX_W'(hit) : '0;
        result.range_error <= 1'b0;
      end
    end
  end

  racl_ram #(.WIDTH(ELEM_W), .DEPTH(MAX_ELEMENTS), .AW(AW)) u_elem (
    .clk(clk),
    .we(elem_we),
    .addr(AW'(idx)),
    .wdata(elem_wdata),
    .rdata(elem_rdata)
  );

  racl_ram #(.WIDTH(ELEM_W), .DEPTH(1 << BW), .AW(BW)) u_pend (
    .clk(clk),
    .we(pend_we),
    .addr(pend_addr),
    .wdata(pend_wdata),
    .rdata(pend_rdata)
  );

`ifndef ASSERT_OFF
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    done && result.range_error |-> result.count == '0)
    else $error("range error with nonzero count");
  a_clr_busy: assert property (@(posedge clk) disable iff (rst)
    state == S_CLR |-> busy)
    else $error("idle during pending clear");
  a_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy || done)
    else $error("accepted transfer dropped");
`endif

endmodule
